// ----- rtl/wss_pkg.sv -----
// Package with shared types and constants of the subpixel splat block.
package wss_pkg;

  localparam int KIND_W    = 2;
  localparam int POS_W     = 6;
  localparam int FRAC_W    = 8;
  localparam int CH_W      = 8;
  localparam int OUT_POS_W = 7;
  localparam int PIX_W     = 3 * CH_W;
  localparam int IDX_W     = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_SPLAT = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_READ  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FIRST,
    ST_STEP
  } state_t;

  typedef struct packed {
    logic             load;
    logic             clear;
    logic             fetch;
    logic             commit;
    logic [IDX_W-1:0] idx;
  } wss_cmd_t;

  typedef struct packed {
    logic  clear_done;
    logic  out_free;
    kind_t item_kind;
  } wss_sts_t;

endpackage

// ----- rtl/wss_in_if.sv -----
// Input channel interface: one splat, write or read word.
interface wss_in_if;
  import wss_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [KIND_W-1:0]    kind;
  logic [POS_W-1:0]     pos_x;
  logic [POS_W-1:0]     pos_y;
  logic [FRAC_W-1:0]    frac_x;
  logic [FRAC_W-1:0]    frac_y;
  logic [CH_W-1:0]      red_in;
  logic [CH_W-1:0]      green_in;
  logic [CH_W-1:0]      blue_in;

  modport source (
    output valid, kind, pos_x, pos_y, frac_x, frac_y, red_in, green_in, blue_in,
    input  ready
  );

  modport sink (
    input  valid, kind, pos_x, pos_y, frac_x, frac_y, red_in, green_in, blue_in,
    output ready
  );

endinterface

// ----- rtl/wss_out_if.sv -----
// Output channel interface: one word per pixel touched.
interface wss_out_if;
  import wss_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [OUT_POS_W-1:0] out_x;
  logic [OUT_POS_W-1:0] out_y;
  logic [CH_W-1:0]      red_out;
  logic [CH_W-1:0]      green_out;
  logic [CH_W-1:0]      blue_out;
  logic                 inside_res;
  logic                 last;

  modport source (
    output valid, out_x, out_y, red_out, green_out, blue_out, inside_res, last,
    input  ready
  );

  modport sink (
    input  valid, out_x, out_y, red_out, green_out, blue_out, inside_res, last,
    output ready
  );

endinterface

// ----- rtl/wu_subpixel_splat.sv -----
// Wu antialiased subpixel splat into a COLS by ROWS RGB frame store.
// After reset the block sweeps the frame memory to black, one pixel per cycle, and
// takes no word during that pass. A splat then goes from accept through a first read
// to one read-modify-write per pixel for four pixels, and a write or read from accept
// through a first read to one commit; a commit waits while the output register is
// full and not taken. Each pixel costs one pass through the frame memory, whose
// registered read port puts the first read before the first pixel. Results wait in an
// output register, and the next word is taken while the last result still waits there.
module wu_subpixel_splat #(
  parameter int COLS = 16,
  parameter int ROWS = 16
) (
  input  logic      clk,
  input  logic      rst,
  wss_in_if.sink    item,
  wss_out_if.source result
);
  import wss_pkg::*;

  wss_cmd_t cmd;
  wss_sts_t sts;
  logic     in_ready;

  assign item.ready = in_ready;

  wss_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item.valid),
    .in_kind  (kind_t'(item.kind)),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  wss_datapath #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .result (result),
    .cmd    (cmd),
    .sts    (sts)
  );

endmodule

// ----- rtl/wss_ctrl.sv -----
// Controller state machine: clearing pass, item accept and pixel sequencing.
module wss_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  wss_pkg::kind_t    in_kind,
  output logic              in_ready,
  input  wss_pkg::wss_sts_t sts,
  output wss_pkg::wss_cmd_t cmd
);
  import wss_pkg::*;

  state_t           state;
  state_t           state_next;
  logic [IDX_W-1:0] cnt;
  logic [IDX_W-1:0] cnt_next;
  logic             final_pix;

  assign final_pix = (sts.item_kind != KIND_SPLAT) || (cnt == {IDX_W{1'b1}});

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    case (state)
      ST_CLEAR: begin
        if (sts.clear_done) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid && (in_kind != KIND_NONE)) state_next = ST_FIRST;
      end
      ST_FIRST: begin
        state_next = ST_STEP;
        cnt_next   = '0;
      end
      ST_STEP: begin
        if (sts.out_free) begin
          if (final_pix) state_next = ST_IDLE;
          else cnt_next = cnt + 1'b1;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_FIRST: begin
        cmd.fetch = 1'b1;
        cmd.idx   = '0;
      end
      ST_STEP: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          cmd.fetch  = !final_pix;
          cmd.idx    = cnt + 1'b1;
        end
      end
      default: cmd = '0;
    endcase
  end

endmodule

// ----- rtl/wss_datapath.sv -----
// Datapath: item registers, Wu weights, frame memory and output register.
module wss_datapath #(
  parameter int COLS = 16,
  parameter int ROWS = 16
) (
  input  logic              clk,
  input  logic              rst,
  wss_in_if.sink            item,
  wss_out_if.source         result,
  input  wss_pkg::wss_cmd_t cmd,
  output wss_pkg::wss_sts_t sts
);
  import wss_pkg::*;

  localparam int DEPTH = COLS * ROWS;
  localparam int AW    = $clog2(DEPTH);
  localparam int WA_W  = 14;

  function automatic logic [CH_W-1:0] corner_wt(input logic [FRAC_W-1:0] a,
                                                input logic [FRAC_W-1:0] b);
    logic [2*FRAC_W-1:0] s;
    s = a * b + {{FRAC_W{1'b0}}, a} + {{FRAC_W{1'b0}}, b};
    return s[2*FRAC_W-1:FRAC_W];
  endfunction

  function automatic logic [CH_W-1:0] sat_add(input logic [CH_W-1:0] base,
                                              input logic [CH_W-1:0] c,
                                              input logic [CH_W-1:0] w);
    logic [2*CH_W-1:0] prod;
    logic [CH_W:0]     s;
    prod = c * w;
    s    = {1'b0, base} + {1'b0, prod[2*CH_W-1:CH_W]};
    return s[CH_W] ? {CH_W{1'b1}} : s[CH_W-1:0];
  endfunction

  kind_t               kind_r;
  logic [POS_W-1:0]    x_r;
  logic [POS_W-1:0]    y_r;
  logic [FRAC_W-1:0]   fx;
  logic [FRAC_W-1:0]   fy;
  logic [CH_W-1:0]     cr;
  logic [CH_W-1:0]     cg;
  logic [CH_W-1:0]     cb;

  logic [OUT_POS_W-1:0] f_x;
  logic [OUT_POS_W-1:0] f_y;
  logic                 f_in;
  logic [WA_W-1:0]      f_addr_wide;
  logic [AW-1:0]        f_addr;
  logic [FRAC_W-1:0]    f_a;
  logic [FRAC_W-1:0]    f_b;

  logic [OUT_POS_W-1:0] p_x;
  logic [OUT_POS_W-1:0] p_y;
  logic                 p_in;
  logic                 p_last;
  logic [AW-1:0]        p_addr;
  logic [CH_W-1:0]      p_w;

  logic [PIX_W-1:0]     mem [DEPTH];
  logic [PIX_W-1:0]     rdata;
  logic [AW-1:0]        clr_addr;
  logic                 mem_we;
  logic [AW-1:0]        mem_wa;
  logic [PIX_W-1:0]     mem_wd;
  logic [PIX_W-1:0]     pix_new;
  logic                 out_valid;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= kind_t'(item.kind);
      x_r    <= item.pos_x;
      y_r    <= item.pos_y;
      fx     <= item.frac_x;
      fy     <= item.frac_y;
      cr     <= item.red_in;
      cg     <= item.green_in;
      cb     <= item.blue_in;
    end
  end

  assign f_x         = {1'b0, x_r} + {{(OUT_POS_W-1){1'b0}}, cmd.idx[0]};
  assign f_y         = {1'b0, y_r} + {{(OUT_POS_W-1){1'b0}}, cmd.idx[1]};
  assign f_in        = (f_x < OUT_POS_W'(COLS)) && (f_y < OUT_POS_W'(ROWS));
  assign f_addr_wide = WA_W'(f_y) * WA_W'(COLS) + WA_W'(f_x);
  assign f_addr      = f_addr_wide[AW-1:0];
  assign f_a         = cmd.idx[0] ? fx : ~fx;
  assign f_b         = cmd.idx[1] ? fy : ~fy;

  always_ff @(posedge clk) begin
    if (cmd.fetch) begin
      p_x    <= f_x;
      p_y    <= f_y;
      p_in   <= f_in;
      p_addr <= f_addr;
      p_w    <= corner_wt(f_a, f_b);
      p_last <= (kind_r != KIND_SPLAT) || (cmd.idx == {IDX_W{1'b1}});
    end
  end

  always_comb begin
    case (kind_r)
      KIND_SPLAT: pix_new = {sat_add(rdata[PIX_W-1:2*CH_W], cr, p_w),
                             sat_add(rdata[2*CH_W-1:CH_W], cg, p_w),
                             sat_add(rdata[CH_W-1:0], cb, p_w)};
      KIND_WRITE: pix_new = {cr, cg, cb};
      default:    pix_new = rdata;
    endcase
  end

  assign mem_we = cmd.clear || (cmd.commit && p_in &&
                  (kind_r == KIND_SPLAT || kind_r == KIND_WRITE));
  assign mem_wa = cmd.clear ? clr_addr : p_addr;
  assign mem_wd = cmd.clear ? '0 : pix_new;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (cmd.fetch && f_in) rdata <= mem[f_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      result.out_x      <= p_x;
      result.out_y      <= p_y;
      result.red_out    <= p_in ? pix_new[PIX_W-1:2*CH_W] : '0;
      result.green_out  <= p_in ? pix_new[2*CH_W-1:CH_W] : '0;
      result.blue_out   <= p_in ? pix_new[CH_W-1:0] : '0;
      result.inside_res <= p_in;
      result.last       <= p_last;
    end
  end

  assign result.valid   = out_valid;
  assign sts.out_free   = !out_valid || result.ready;
  assign sts.clear_done = (clr_addr == AW'(DEPTH - 1));
  assign sts.item_kind  = kind_r;

endmodule

// ----- rtl/wss_checker.sv -----
// Port checker for the subpixel splat block, with its bind.
module wss_checker #(
  parameter int COLS = 16,
  parameter int ROWS = 16
) (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [6:0] out_x,
  input logic [6:0] out_y,
  input logic [7:0] red_out,
  input logic [7:0] green_out,
  input logic [7:0] blue_out,
  input logic       inside_res,
  input logic       last
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y) &&
      $stable(red_out) && $stable(green_out) && $stable(blue_out) &&
      $stable(inside_res) && $stable(last))
    else $error("stalled result word changed");

  a_inside: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> inside_res == ((out_x < 7'(COLS)) && (out_y < 7'(ROWS))))
    else $error("inside flag disagrees with position");

  a_black: assert property (@(posedge clk) disable iff (rst)
    out_valid && !inside_res |-> red_out == 8'd0 && green_out == 8'd0 && blue_out == 8'd0)
    else $error("skipped pixel carries a colour");

  a_no_accept: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> !(in_valid && in_ready))
    else $error("word accepted while results of previous word pending");

endmodule

bind wu_subpixel_splat wss_checker #(
  .COLS (COLS),
  .ROWS (ROWS)
) u_wss_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (item.valid),
  .in_ready   (item.ready),
  .out_valid  (result.valid),
  .out_ready  (result.ready),
  .out_x      (result.out_x),
  .out_y      (result.out_y),
  .red_out    (result.red_out),
  .green_out  (result.green_out),
  .blue_out   (result.blue_out),
  .inside_res (result.inside_res),
  .last       (result.last)
);
